[hw/rtl/hvflf_pkg.sv]
// Shared types and constants for the haptic velocity filter and lock force block
`default_nettype none
package hvflf_pkg;
    localparam int unsigned AXES = 3;
    localparam logic [37:0] C_B0   = 38'd943175;
    localparam logic [37:0] C_B1   = 38'd2829524;
    localparam logic [37:0] C_A1   = 38'd11806006103;
    localparam logic [37:0] C_A2   = 38'd10858536318;
    localparam logic [37:0] C_A3   = 38'd3339766569;
    localparam logic [37:0] C_DAMP = 38'd4294967;

    localparam logic [1:0] UNIT_MM = 2'd0;
    localparam logic [1:0] UNIT_CM = 2'd1;
    localparam logic [1:0] UNIT_DM = 2'd2;
    localparam logic [1:0] UNIT_M  = 2'd3;

    // Sequencer opcodes for the datapath
    localparam logic [3:0] OP_IDLE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_SCALE  = 4'd2;
    localparam logic [3:0] OP_RAW    = 4'd3;
    localparam logic [3:0] OP_MB0    = 4'd4;
    localparam logic [3:0] OP_MB1    = 4'd5;
    localparam logic [3:0] OP_MA1    = 4'd6;
    localparam logic [3:0] OP_MA2    = 4'd7;
    localparam logic [3:0] OP_MA3    = 4'd8;
    localparam logic [3:0] OP_VSAT   = 4'd9;
    localparam logic [3:0] OP_SPRING = 4'd10;
    localparam logic [3:0] OP_DAMP   = 4'd11;
    localparam logic [3:0] OP_COMMIT = 4'd12;
    localparam logic [3:0] OP_FBDAMP = 4'd13;
    localparam logic [3:0] OP_FBSTORE = 4'd14;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] axis;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
    } dp_stat_t;

    function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                                  input int unsigned bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
            sat64 = hi;
        else if (v < lo)
            sat64 = lo;
        else
            sat64 = v;
    endfunction
endpackage
`default_nettype wire

[hw/rtl/haptic_velocity_filter_lock_force.sv]
// Top level of the three-axis haptic velocity filter and lock force servo step
//
//  channel | signals                        | direction | carries
//  in      | in_valid/in_ready + fields     | input     | sample or feedback item
//  out     | out_valid/out_ready + fields   | output    | force, velocity, lock
//  cfg     | cfg_valid/cfg_ready, cfg_data  | input     | unit_select
//
// A sample item works the axes in turn, per axis a u-pass divide by ten and
// seven products through the one shared multiplier, u = unit_select (0 to 3).
// A feedback item makes one damping product per axis and gives no result.
// Reset clears all history, the lock point, the held force and the lock flag.
// Results wait in an output register; a stalled output holds the next sample
// item at the end of its work until the register frees. Config is taken only
// while the sequencer is idle.
`default_nettype none
module haptic_velocity_filter_lock_force (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               kind,
    input  wire logic signed [31:0] raw_pos_x,
    input  wire logic signed [31:0] raw_pos_y,
    input  wire logic signed [31:0] raw_pos_z,
    input  wire logic [1:0]         buttons_now,
    input  wire logic signed [31:0] cmd_force_x,
    input  wire logic signed [31:0] cmd_force_y,
    input  wire logic signed [31:0] cmd_force_z,
    input  wire logic signed [31:0] hold_x,
    input  wire logic signed [31:0] hold_y,
    input  wire logic signed [31:0] hold_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      drive_x,
    output logic signed [31:0]      drive_y,
    output logic signed [31:0]      drive_z,
    output logic signed [31:0]      vel_x,
    output logic signed [31:0]      vel_y,
    output logic signed [31:0]      vel_z,
    output logic                    locked,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_data
);
    logic [1:0]          unit_reg;
    logic                take, out_load;
    hvflf_pkg::dp_cmd_t  cmd;
    hvflf_pkg::dp_stat_t stat;
    logic signed [31:0]  frc [3];
    logic signed [31:0]  vel [3];
    logic                lk;
    logic                ov_reg;

    // Accept a unit write only while no item is being worked on
    assign cfg_ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= hvflf_pkg::UNIT_MM;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                unit_reg <= cfg_data;
            if (out_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    hvflf_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .out_slot_free (!ov_reg || out_ready),
        .out_load      (out_load),
        .take          (take),
        .cmd           (cmd),
        .stat          (stat)
    );

    hvflf_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .take        (take),
        .unit_sel    (unit_reg),
        .raw_pos_x   (raw_pos_x),
        .raw_pos_y   (raw_pos_y),
        .raw_pos_z   (raw_pos_z),
        .buttons_now (buttons_now),
        .cmd_force_x (cmd_force_x),
        .cmd_force_y (cmd_force_y),
        .cmd_force_z (cmd_force_z),
        .hold_x      (hold_x),
        .hold_y      (hold_y),
        .hold_z      (hold_z),
        .force_o     (frc),
        .vel_o       (vel),
        .lock_o      (lk)
    );

    // Remap force to the device frame; negating the minimum saturates
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            drive_x <= frc[0];
            drive_y <= frc[2];
            drive_z <= (frc[1] == 32'sh80000000) ? 32'sh7fffffff : -frc[1];
            vel_x   <= vel[0];
            vel_y   <= vel[1];
            vel_z   <= vel[2];
            locked  <= lk;
        end
    end

    assign out_valid = ov_reg;
endmodule
`default_nettype wire

[hw/rtl/hvflf_qmul.sv]
// Multi-cycle rounded Q6.32 multiplier: |a| < 2^49 times c < 2^38, four 32x32 partials
`default_nettype none
module hvflf_qmul (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [63:0] a,
    input  wire logic [37:0]        c,
    output logic                    done,
    output logic signed [63:0]      product
);
    logic [2:0]  step_reg, step_next;
    logic        neg_reg;
    logic [63:0] mag_reg;
    logic [37:0] c_reg;
    logic [63:0] pp_reg;
    logic [95:0] acc_reg;
    logic [31:0] ma, mc;

    always_comb
    begin
        step_next = step_reg;
        if (start)
            step_next = 3'd1;
        else if (step_reg != 3'd0)
            step_next = (step_reg == 3'd5) ? 3'd0 : step_reg + 3'd1;
    end

    // Partial selection: step1 a0*c0, step2 a1*c0, step3 a0*c1, step4 a1*c1
    always_comb
    begin
        ma = (step_reg == 3'd2 || step_reg == 3'd4) ? mag_reg[63:32] : mag_reg[31:0];
        mc = (step_reg == 3'd3 || step_reg == 3'd4) ? {26'd0, c_reg[37:32]} : c_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= a[63];
            mag_reg <= a[63] ? 64'(-a) : 64'(a);
            c_reg   <= c;
            acc_reg <= '0;
        end
        else
        begin
            if (step_reg >= 3'd1 && step_reg <= 3'd4)
                pp_reg <= ma * mc;
            case (step_reg)
                3'd2: acc_reg <= acc_reg + {32'd0, pp_reg};
                3'd3: acc_reg <= acc_reg + {pp_reg, 32'd0};
                3'd4: acc_reg <= acc_reg + {pp_reg, 32'd0};
                3'd5: acc_reg <= acc_reg + {pp_reg[31:0], 64'd0};
                default: ;
            endcase
        end
    end

    logic [63:0] rnd;
    assign rnd = acc_reg[95:32] + {63'd0, acc_reg[31]};
    assign product = neg_reg ? -$signed(rnd) : $signed(rnd);
    assign done = (step_reg == 3'd0) && !start;
endmodule
`default_nettype wire

[hw/rtl/hvflf_datapath.sv]
// Datapath: state arrays, unit divider, velocity filter and force accumulation
`default_nettype none
module hvflf_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hvflf_pkg::dp_cmd_t cmd,
    output hvflf_pkg::dp_stat_t     stat,
    input  wire logic               take,
    input  wire logic [1:0]         unit_sel,
    input  wire logic signed [31:0] raw_pos_x,
    input  wire logic signed [31:0] raw_pos_y,
    input  wire logic signed [31:0] raw_pos_z,
    input  wire logic [1:0]         buttons_now,
    input  wire logic signed [31:0] cmd_force_x,
    input  wire logic signed [31:0] cmd_force_y,
    input  wire logic signed [31:0] cmd_force_z,
    input  wire logic signed [31:0] hold_x,
    input  wire logic signed [31:0] hold_y,
    input  wire logic signed [31:0] hold_z,
    output logic signed [31:0]      force_o [3],
    output logic signed [31:0]      vel_o [3],
    output logic                    lock_o
);
    logic signed [31:0] dev_reg [3];
    logic signed [31:0] cmdf_reg [3];
    logic signed [31:0] hold_in_reg [3];
    logic [1:0]         btn_reg;
    logic signed [31:0] ph1_reg [3], ph2_reg [3];
    logic signed [47:0] rv_reg [3][3];
    logic signed [47:0] fv_reg [3][3];
    logic signed [31:0] lp_reg [3];
    logic signed [31:0] hf_reg [3];
    logic               lock_reg, lock_next;
    logic signed [31:0] p_reg;
    logic signed [47:0] r_reg;
    logic signed [63:0] acc_reg;
    logic signed [47:0] v_reg;
    logic [1:0]         ax;
    assign ax = cmd.axis;

    // Unit divider: truncate the magnitude by ten once per pass, one pass per
    // unit step (mm none, cm one, dm two, m three); floor of a floor is exact
    logic [1:0]         dcnt_reg;
    logic [31:0]        dnum_reg;
    logic               dneg_reg;
    logic [63:0]        dprod;
    logic signed [32:0] dsrc;
    logic [31:0]        dmag;

    assign dprod = 64'(dnum_reg) * 64'(32'hCCCCCCCD);

    always_comb
    begin
        dsrc = (ax == 2'd1) ? -33'(dev_reg[ax]) : 33'(dev_reg[ax]);
        dmag = dsrc[32] ? 32'(-dsrc) : 32'(dsrc);
    end

    // Multiplier operand select
    logic               mstart;
    logic signed [63:0] ma;
    logic [37:0]        mc;
    logic               mdone;
    logic signed [63:0] mprod;
    logic [37:0]        gain;
    logic signed [63:0] qq;
    logic signed [63:0] raw_full;

    always_comb
    begin
        case (unit_sel)
            hvflf_pkg::UNIT_MM: gain = 38'd171798692;
            hvflf_pkg::UNIT_CM: gain = 38'd1717986918;
            hvflf_pkg::UNIT_DM: gain = 38'd17179869184;
            default:            gain = 38'd171798691840;
        endcase
    end

    always_comb
    begin
        mstart = 1'b0;
        ma = '0;
        mc = '0;
        case (cmd.op)
            hvflf_pkg::OP_MB0:
            begin
                // Raw velocity of this item goes straight in; r_reg loads at this edge
                mstart = 1'b1;
                ma = hvflf_pkg::sat64(raw_full, 48) + 64'(rv_reg[ax][2]);
                mc = hvflf_pkg::C_B0;
            end
            hvflf_pkg::OP_MB1:
            begin
                mstart = 1'b1;
                ma = 64'(rv_reg[ax][0]) + 64'(rv_reg[ax][1]);
                mc = hvflf_pkg::C_B1;
            end
            hvflf_pkg::OP_MA1:
            begin
                mstart = 1'b1; ma = 64'(fv_reg[ax][0]); mc = hvflf_pkg::C_A1;
            end
            hvflf_pkg::OP_MA2:
            begin
                mstart = 1'b1; ma = 64'(fv_reg[ax][1]); mc = hvflf_pkg::C_A2;
            end
            hvflf_pkg::OP_MA3:
            begin
                mstart = 1'b1; ma = 64'(fv_reg[ax][2]); mc = hvflf_pkg::C_A3;
            end
            hvflf_pkg::OP_SPRING:
            begin
                mstart = 1'b1; ma = 64'(lp_reg[ax]) - 64'(p_reg); mc = gain;
            end
            hvflf_pkg::OP_DAMP:
            begin
                mstart = 1'b1; ma = 64'(v_reg); mc = hvflf_pkg::C_DAMP;
            end
            hvflf_pkg::OP_FBDAMP:
            begin
                mstart = 1'b1; ma = 64'(fv_reg[ax][0]); mc = hvflf_pkg::C_DAMP;
            end
            default: ;
        endcase
    end

    hvflf_qmul u_qmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mstart),
        .a       (ma),
        .c       (mc),
        .done    (mdone),
        .product (mprod)
    );

    assign stat.mul_done = mdone;
    assign stat.div_done = (dcnt_reg == 2'd0);

    always_comb
    begin
        lock_next = lock_reg;
        if (btn_reg[0])
            lock_next = 1'b1;
        if (btn_reg[1])
            lock_next = 1'b0;
    end

    always_comb
    begin
        qq = dneg_reg ? -$signed({32'd0, dnum_reg}) : $signed({32'd0, dnum_reg});
        raw_full = (64'sd3 * 64'(p_reg) - 64'sd4 * 64'(ph1_reg[ax]) + 64'(ph2_reg[ax]))
                   * 64'sd500;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
            lock_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                ph1_reg[i] <= '0;
                ph2_reg[i] <= '0;
                lp_reg[i]  <= '0;
                hf_reg[i]  <= '0;
                for (int j = 0; j < 3; j++)
                begin
                    rv_reg[i][j] <= '0;
                    fv_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            if (cmd.op == hvflf_pkg::OP_LOAD)
                lock_reg <= lock_next;
            if (cmd.op == hvflf_pkg::OP_SCALE)
                dcnt_reg <= unit_sel;
            else if (dcnt_reg != 2'd0)
                dcnt_reg <= dcnt_reg - 2'd1;
            if (cmd.op == hvflf_pkg::OP_COMMIT)
            begin
                ph2_reg[ax] <= ph1_reg[ax];
                ph1_reg[ax] <= p_reg;
                rv_reg[ax][2] <= rv_reg[ax][1];
                rv_reg[ax][1] <= rv_reg[ax][0];
                rv_reg[ax][0] <= r_reg;
                fv_reg[ax][2] <= fv_reg[ax][1];
                fv_reg[ax][1] <= fv_reg[ax][0];
                fv_reg[ax][0] <= v_reg;
                if (lock_reg)
                    hf_reg[ax] <= 32'(hvflf_pkg::sat64(acc_reg - mprod, 32));
            end
            if (cmd.op == hvflf_pkg::OP_FBSTORE)
            begin
                hf_reg[ax] <= 32'(hvflf_pkg::sat64(64'(cmdf_reg[ax]) - mprod, 32));
                lp_reg[ax] <= hold_in_reg[ax];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dev_reg[0] <= raw_pos_x;
            dev_reg[1] <= raw_pos_z;   // negated at divide time
            dev_reg[2] <= raw_pos_y;
            cmdf_reg[0] <= cmd_force_x;
            cmdf_reg[1] <= cmd_force_y;
            cmdf_reg[2] <= cmd_force_z;
            hold_in_reg[0] <= hold_x;
            hold_in_reg[1] <= hold_y;
            hold_in_reg[2] <= hold_z;
            btn_reg <= buttons_now;
        end
        case (cmd.op)
            hvflf_pkg::OP_SCALE:
            begin
                dneg_reg <= dsrc[32];
                dnum_reg <= dmag;
            end
            hvflf_pkg::OP_RAW:
            begin
                p_reg <= 32'(hvflf_pkg::sat64(qq, 32));
            end
            hvflf_pkg::OP_MB0:
                r_reg <= 48'(hvflf_pkg::sat64(raw_full, 48));
            hvflf_pkg::OP_MB1, hvflf_pkg::OP_MA1, hvflf_pkg::OP_MA2,
            hvflf_pkg::OP_MA3, hvflf_pkg::OP_VSAT:
            begin
                if (cmd.op == hvflf_pkg::OP_MB1)
                    acc_reg <= mprod;
                else if (cmd.op == hvflf_pkg::OP_MA2)
                    acc_reg <= acc_reg + mprod;
                else if (cmd.op == hvflf_pkg::OP_MA3)
                    acc_reg <= acc_reg - mprod;
                else
                    acc_reg <= acc_reg + mprod;
                if (cmd.op == hvflf_pkg::OP_VSAT)
                    v_reg <= 48'(hvflf_pkg::sat64(acc_reg + mprod, 48));
            end
            hvflf_pkg::OP_DAMP:
                acc_reg <= mprod;
            default: ;
        endcase
        if (cmd.op != hvflf_pkg::OP_SCALE && dcnt_reg != 2'd0)
            dnum_reg <= {3'd0, dprod[63:35]};
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            force_o[i] = hf_reg[i];
            vel_o[i]   = 32'(hvflf_pkg::sat64(64'(fv_reg[i][0]), 32));
        end
        lock_o = lock_reg;
    end
endmodule
`default_nettype wire

[hw/rtl/hvflf_ctrl.sv]
// Sequencer for sample and feedback items
`default_nettype none
module hvflf_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               kind,
    input  wire logic               out_slot_free,
    output logic                    out_load,
    output logic                    take,
    output hvflf_pkg::dp_cmd_t      cmd,
    input  wire hvflf_pkg::dp_stat_t stat
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;

    logic [2:0] st_reg, st_next;
    logic [3:0] op_reg, op_next;
    logic [1:0] ax_reg, ax_next;
    logic       fb_reg, fb_next;

    assign in_ready = (st_reg == S_IDLE);
    assign take = in_valid && in_ready;

    // Next opcode after the current one for this axis
    function automatic logic [3:0] succ(input logic [3:0] op);
        case (op)
            hvflf_pkg::OP_LOAD:   succ = hvflf_pkg::OP_SCALE;
            hvflf_pkg::OP_SCALE:  succ = hvflf_pkg::OP_RAW;
            hvflf_pkg::OP_RAW:    succ = hvflf_pkg::OP_MB0;
            hvflf_pkg::OP_MB0:    succ = hvflf_pkg::OP_MB1;
            hvflf_pkg::OP_MB1:    succ = hvflf_pkg::OP_MA1;
            hvflf_pkg::OP_MA1:    succ = hvflf_pkg::OP_MA2;
            hvflf_pkg::OP_MA2:    succ = hvflf_pkg::OP_MA3;
            hvflf_pkg::OP_MA3:    succ = hvflf_pkg::OP_VSAT;
            hvflf_pkg::OP_VSAT:   succ = hvflf_pkg::OP_SPRING;
            hvflf_pkg::OP_SPRING: succ = hvflf_pkg::OP_DAMP;
            hvflf_pkg::OP_DAMP:   succ = hvflf_pkg::OP_COMMIT;
            hvflf_pkg::OP_FBDAMP: succ = hvflf_pkg::OP_FBSTORE;
            default:              succ = hvflf_pkg::OP_IDLE;
        endcase
    endfunction

    always_comb
    begin
        st_next = st_reg;
        op_next = op_reg;
        ax_next = ax_reg;
        fb_next = fb_reg;
        cmd.op = hvflf_pkg::OP_IDLE;
        cmd.axis = ax_reg;
        out_load = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    fb_next = kind;
                    ax_next = 2'd0;
                    op_next = kind ? hvflf_pkg::OP_FBDAMP : hvflf_pkg::OP_LOAD;
                    st_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cmd.op = op_reg;
                if (op_reg == hvflf_pkg::OP_LOAD)
                    op_next = hvflf_pkg::OP_SCALE;
                else if (op_reg == hvflf_pkg::OP_COMMIT
                         || op_reg == hvflf_pkg::OP_FBSTORE)
                begin
                    if (ax_reg == 2'd2)
                        st_next = fb_reg ? S_IDLE : S_EMIT;
                    else
                    begin
                        ax_next = ax_reg + 2'd1;
                        op_next = fb_reg ? hvflf_pkg::OP_FBDAMP : hvflf_pkg::OP_SCALE;
                    end
                end
                else
                begin
                    op_next = succ(op_reg);
                    st_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (stat.div_done && stat.mul_done)
                    st_next = S_ISSUE;
            end
            S_EMIT:
            begin
                if (out_slot_free)
                begin
                    out_load = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            op_reg <= hvflf_pkg::OP_IDLE;
            ax_reg <= 2'd0;
            fb_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            op_reg <= op_next;
            ax_reg <= ax_next;
            fb_reg <= fb_next;
        end
    end
endmodule
`default_nettype wire
